[rtl/rcvm_pkg.sv]
// Shared types, register and mode codes, and helpers for the range and center value mapper.
// No dependencies.
package rcvm_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned CNT_WIDTH  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_CTR_NEG = 2'd1,
    MODE_CTR_POS = 2'd2,
    MODE_HOLD    = 2'd3
  } map_mode_e;

  typedef enum logic [2:0] {
    REG_MAP_MODE    = 3'd0,
    REG_SOURCE      = 3'd1,
    REG_PARAM_ONE   = 3'd2,
    REG_PARAM_TWO   = 3'd3,
    REG_PARAM_THREE = 3'd4,
    REG_PARAM_FOUR  = 3'd5,
    REG_DEAD_ZONE   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MAG,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_FIN,
    ST_ZONE,
    ST_SEL,
    ST_DONE
  } state_e;

  // keep the low DATA_WIDTH bits, sign extend to 32
  function automatic logic [31:0] fit_width(input logic [63:0] v);
    logic signed [DATA_WIDTH-1:0] low;
    low = v[DATA_WIDTH-1:0];
    return 32'(low);
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] neg;
    neg = -v;
    return v[32] ? neg[31:0] : v[31:0];
  endfunction

endpackage

[rtl/range_and_center_value_mapper.sv]
// Range and center value mapper: linear range map, center-side map or hold of one sample.
// Uses rcvm_pkg. Shared 32x32 multiplier feeding a radix-2 64/32 divider.
// The divider runs 64 steps. Hold and digital-source beats, linear beats with equal input
// bounds, and center beats with a zero side range skip the multiply and divide. A new beat is
// accepted in the cycle after the result loads; no new sample is taken while one is in flight.
// Reset: asynchronous, active low; config registers and last output clear to 0.
module range_and_center_value_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               raw_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               mapped_value_o,
  output logic                             held_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcvm_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rcvm_pkg::*;

  map_mode_e          map_mode_q;
  logic               source_q;
  logic signed [31:0] p1_q, p2_q, p3_q, p4_q, dz_q;
  logic [31:0]        last_q;

  state_e             state_q, state_d;
  logic signed [31:0] x_q;
  logic signed [32:0] a_q, b_q, c_q;
  logic [31:0]        mag_a_q, mag_b_q, mag_c_q;
  logic               neg_q;
  logic [63:0]        quo_q;
  logic [31:0]        rem_q;
  logic [CNT_WIDTH-1:0] cnt_q;
  logic signed [63:0] n_q;
  logic [31:0]        res_q;
  logic               held_q;
  logic               out_valid_q;
  logic signed [31:0] mapped_q;
  logic               held_out_q;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               early_exit, zero_range, x_le_c, is_center;
  logic signed [31:0] ctr_range;
  logic [32:0]        trial, diff;
  logic               ge;
  logic signed [63:0] p4_64, p4_neg64;
  logic signed [33:0] n34, dz34, dz_neg34;
  logic [33:0]        n_neg34;
  logic               in_zone;
  logic               out_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_WIDTH-1:2];

  always_comb begin
    case (cfg_idx)
      REG_MAP_MODE:    prdata = {30'd0, map_mode_q};
      REG_SOURCE:      prdata = {31'd0, source_q};
      REG_PARAM_ONE:   prdata = p1_q;
      REG_PARAM_TWO:   prdata = p2_q;
      REG_PARAM_THREE: prdata = p3_q;
      REG_PARAM_FOUR:  prdata = p4_q;
      REG_DEAD_ZONE:   prdata = dz_q;
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q <= MODE_LINEAR;
      source_q   <= 1'b0;
      p1_q       <= '0;
      p2_q       <= '0;
      p3_q       <= '0;
      p4_q       <= '0;
      dz_q       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAP_MODE:    map_mode_q <= map_mode_e'(pwdata[1:0]);
        REG_SOURCE:      source_q   <= pwdata[0];
        REG_PARAM_ONE:   p1_q       <= pwdata;
        REG_PARAM_TWO:   p2_q       <= pwdata;
        REG_PARAM_THREE: p3_q       <= pwdata;
        REG_PARAM_FOUR:  p4_q       <= pwdata;
        REG_DEAD_ZONE:   dz_q       <= pwdata;
        default: ;
      endcase
    end
  end

  // decode of the item
  assign is_center  = (map_mode_q == MODE_CTR_NEG) || (map_mode_q == MODE_CTR_POS);
  assign x_le_c     = x_q <= p1_q;
  assign ctr_range  = x_le_c ? p2_q : p3_q;
  assign early_exit = !source_q || (map_mode_q == MODE_HOLD) ||
                      ((map_mode_q == MODE_LINEAR) && (p2_q == p1_q));
  assign zero_range = is_center && (ctr_range == 32'sd0);

  // divider step
  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, mag_c_q};
  assign diff  = trial - {1'b0, mag_c_q};

  // clamp and dead zone
  assign p4_64    = 64'(p4_q);
  assign p4_neg64 = -p4_64;
  assign n34      = n_q[33:0];
  assign dz34     = 34'(dz_q);
  assign dz_neg34 = -dz34;
  assign n_neg34  = -n34;
  assign in_zone  = (n34 > dz_neg34) && (n34 < dz34);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: begin
        if (early_exit) state_d = ST_DONE;
        else if (zero_range) state_d = ST_FIN;
        else state_d = ST_MAG;
      end
      ST_MAG:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CNT_WIDTH'(DIV_STEPS - 1)) state_d = ST_SIGN;
      ST_SIGN: state_d = ST_FIN;
      ST_FIN:  state_d = is_center ? ST_ZONE : ST_DONE;
      ST_ZONE: state_d = ST_SEL;
      ST_SEL:  state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        last_q      <= res_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) x_q <= fit_width(64'(raw_value_i));
      end
      ST_PREP: begin
        held_q <= source_q && early_exit;
        n_q    <= '0;
        a_q    <= 33'(x_q) - 33'(p1_q);
        if (!source_q) begin
          res_q <= '0;
        end else if (early_exit) begin
          res_q <= last_q;
        end
        if (map_mode_q == MODE_LINEAR) begin
          b_q <= 33'(p4_q) - 33'(p3_q);
          c_q <= 33'(p2_q) - 33'(p1_q);
        end else begin
          b_q <= 33'(p4_q);
          c_q <= 33'(ctr_range);
        end
      end
      ST_MAG: begin
        mag_a_q <= mag33(a_q);
        mag_b_q <= mag33(b_q);
        mag_c_q <= mag33(c_q);
        neg_q   <= a_q[32] ^ b_q[32] ^ c_q[32];
      end
      ST_MUL: begin
        quo_q <= 64'(mag_a_q) * 64'(mag_b_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= ge ? diff[31:0] : trial[31:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_SIGN: begin
        n_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
      end
      ST_FIN: begin
        if (is_center) begin
          if (n_q > p4_64) n_q <= p4_64;
          else if (n_q < p4_neg64) n_q <= p4_neg64;
        end else begin
          res_q <= fit_width(n_q + 64'(p3_q));
        end
      end
      ST_ZONE: begin
        if (in_zone) n_q <= '0;
      end
      ST_SEL: begin
        if (map_mode_q == MODE_CTR_NEG) begin
          res_q <= (n34 <= 34'sd0) ? fit_width(64'(n_neg34)) : 32'd0;
        end else begin
          res_q <= (n34 > 34'sd0) ? fit_width(64'(n34)) : 32'd0;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          mapped_q   <= res_q;
          held_out_q <= held_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign mapped_value_o = mapped_q;
  assign held_o         = held_out_q;

endmodule
